>>> hw/rtl/atu_pkg.sv
package atu_pkg;

	// Field widths
	localparam int RAW_W = 16;
	localparam int ACC_W = 18;
	localparam int ANG_W = 16;

	// Square-root datapath: radicand is (b*b + c*c) * 2^16
	localparam int SUM_W = 36;
	localparam int RAD_W = 52;
	localparam int ROOT_W = 26;
	localparam int REM_W = 29;
	localparam int SQRT_STEPS = 26;

	// CORDIC datapath
	localparam int CRD_W = 29;
	localparam int Z_W = 19;
	localparam int CORDIC_STEPS = 17;
	localparam int STEP_W = 5;

	// pi/2 in Q2.13
	localparam int HALF_PI_Q13 = 12868;

	// Sensitivity codes
	localparam logic [1:0] SENS_8G = 2'd0;
	localparam logic [1:0] SENS_4G = 2'd1;
	localparam logic [1:0] SENS_2G = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ_B,
		S_SQ_C,
		S_ROOT_INIT,
		S_ROOT,
		S_CRD_INIT,
		S_CRD,
		S_STORE,
		S_OUT
	} atu_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic              load;
		logic              hold;
		logic              sq_b;
		logic              sq_c;
		logic              root_init;
		logic              root_step;
		logic              crd_init;
		logic              crd_step;
		logic              store;
		logic [1:0]        axis;
		logic [STEP_W-1:0] step;
	} atu_cmd_t;

	// atan(2^-i) * 2^16, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_tab(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] v;
		begin
			case (i)
				5'd0:    v = 19'sd51472;
				5'd1:    v = 19'sd30386;
				5'd2:    v = 19'sd16055;
				5'd3:    v = 19'sd8150;
				5'd4:    v = 19'sd4091;
				5'd5:    v = 19'sd2047;
				5'd6:    v = 19'sd1024;
				5'd7:    v = 19'sd512;
				5'd8:    v = 19'sd256;
				5'd9:    v = 19'sd128;
				5'd10:   v = 19'sd64;
				5'd11:   v = 19'sd32;
				5'd12:   v = 19'sd16;
				5'd13:   v = 19'sd8;
				5'd14:   v = 19'sd4;
				5'd15:   v = 19'sd2;
				5'd16:   v = 19'sd1;
				default: v = 19'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

>>> hw/rtl/atu_sample_if.sv
interface atu_sample_if;
	logic                               valid;
	logic                               ready;
	logic                               data_ready;
	logic signed [atu_pkg::RAW_W-1:0]   raw_x;
	logic signed [atu_pkg::RAW_W-1:0]   raw_y;
	logic signed [atu_pkg::RAW_W-1:0]   raw_z;

	modport source (output valid, data_ready, raw_x, raw_y, raw_z, input ready);
	modport sink (input valid, data_ready, raw_x, raw_y, raw_z, output ready);
endinterface

>>> hw/rtl/atu_result_if.sv
interface atu_result_if;
	logic                               valid;
	logic                               ready;
	logic                               updated;
	logic signed [atu_pkg::ACC_W-1:0]   accel_x;
	logic signed [atu_pkg::ACC_W-1:0]   accel_y;
	logic signed [atu_pkg::ACC_W-1:0]   accel_z;
	logic signed [atu_pkg::ANG_W-1:0]   angle_x;
	logic signed [atu_pkg::ANG_W-1:0]   angle_y;
	logic signed [atu_pkg::ANG_W-1:0]   angle_z;

	modport source (output valid, updated, accel_x, accel_y, accel_z,
		angle_x, angle_y, angle_z, input ready);
	modport sink (input valid, updated, accel_x, accel_y, accel_z,
		angle_x, angle_y, angle_z, output ready);
endinterface

>>> hw/rtl/atu_ctrl.sv
module atu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             data_ready,
	input  logic             out_ready,
	output logic             in_ready,
	output logic             out_valid,
	output atu_pkg::atu_cmd_t cmd
);

	atu_pkg::atu_state_t state_q, state_d;
	logic [1:0]                 axis_q, axis_d;
	logic [atu_pkg::STEP_W-1:0] cnt_q, cnt_d;

	// State, axis and step counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atu_pkg::S_IDLE;
			axis_q  <= 2'd0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		axis_d    = axis_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		cmd.axis  = axis_q;
		cmd.step  = cnt_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			atu_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					axis_d = 2'd0;
					if (data_ready) begin
						cmd.load = 1'b1;
						state_d  = atu_pkg::S_SQ_B;
					end else begin
						cmd.hold = 1'b1;
						state_d  = atu_pkg::S_OUT;
					end
				end
			end
			atu_pkg::S_SQ_B: begin
				cmd.sq_b = 1'b1;
				state_d  = atu_pkg::S_SQ_C;
			end
			atu_pkg::S_SQ_C: begin
				cmd.sq_c = 1'b1;
				state_d  = atu_pkg::S_ROOT_INIT;
			end
			atu_pkg::S_ROOT_INIT: begin
				cmd.root_init = 1'b1;
				cnt_d         = '0;
				state_d       = atu_pkg::S_ROOT;
			end
			atu_pkg::S_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == atu_pkg::STEP_W'(atu_pkg::SQRT_STEPS - 1)) begin
					state_d = atu_pkg::S_CRD_INIT;
				end
			end
			atu_pkg::S_CRD_INIT: begin
				cmd.crd_init = 1'b1;
				cnt_d        = '0;
				state_d      = atu_pkg::S_CRD;
			end
			atu_pkg::S_CRD: begin
				cmd.crd_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == atu_pkg::STEP_W'(atu_pkg::CORDIC_STEPS - 1)) begin
					state_d = atu_pkg::S_STORE;
				end
			end
			atu_pkg::S_STORE: begin
				cmd.store = 1'b1;
				if (axis_q == 2'd2) begin
					state_d = atu_pkg::S_OUT;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = atu_pkg::S_SQ_B;
				end
			end
			atu_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = atu_pkg::S_IDLE;
				end
			end
			default: state_d = atu_pkg::S_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/atu_dp.sv
module atu_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  atu_pkg::atu_cmd_t                cmd,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_wdata,
	input  logic signed [atu_pkg::RAW_W-1:0] raw_x,
	input  logic signed [atu_pkg::RAW_W-1:0] raw_y,
	input  logic signed [atu_pkg::RAW_W-1:0] raw_z,
	output logic                             updated,
	output logic signed [atu_pkg::ACC_W-1:0] accel_x,
	output logic signed [atu_pkg::ACC_W-1:0] accel_y,
	output logic signed [atu_pkg::ACC_W-1:0] accel_z,
	output logic signed [atu_pkg::ANG_W-1:0] angle_x,
	output logic signed [atu_pkg::ANG_W-1:0] angle_y,
	output logic signed [atu_pkg::ANG_W-1:0] angle_z
);

	localparam int ACC_W = atu_pkg::ACC_W;
	localparam int ANG_W = atu_pkg::ANG_W;
	localparam int RAW_W = atu_pkg::RAW_W;
	localparam int SUM_W = atu_pkg::SUM_W;
	localparam int RAD_W = atu_pkg::RAD_W;
	localparam int ROOT_W = atu_pkg::ROOT_W;
	localparam int REM_W = atu_pkg::REM_W;
	localparam int CRD_W = atu_pkg::CRD_W;
	localparam int Z_W = atu_pkg::Z_W;
	localparam int Q_W = Z_W - 2;

	logic [1:0]              sens_q;
	logic                    upd_q;
	logic signed [ACC_W-1:0] acc_q [3];
	logic signed [ANG_W-1:0] ang_q [3];
	logic [SUM_W-1:0]        sum_q;
	logic [RAD_W-1:0]        rad_q;
	logic [REM_W-1:0]        rem_q;
	logic [ROOT_W-1:0]       root_q;
	logic signed [CRD_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]   z_q;

	// Sensitivity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= atu_pkg::SENS_2G;
		end else if (cfg_we) begin
			sens_q <= cfg_wdata;
		end
	end

	// Scaling of raw counts to 1/16384 g
	logic [1:0] shamt;
	always_comb begin
		case (sens_q)
			atu_pkg::SENS_8G: shamt = 2'd2;
			atu_pkg::SENS_4G: shamt = 2'd1;
			default:          shamt = 2'd0;
		endcase
	end

	function automatic logic signed [ACC_W-1:0] scale(input logic signed [RAW_W-1:0] r,
		input logic [1:0] s);
		logic signed [ACC_W-1:0] e;
		begin
			e = ACC_W'(r);
			return e <<< s;
		end
	endfunction

	// Operand selection for the current axis
	logic signed [ACC_W-1:0] a_sel, b_sel, c_sel;
	always_comb begin
		case (cmd.axis)
			2'd0:    begin a_sel = acc_q[0]; b_sel = acc_q[1]; c_sel = acc_q[2]; end
			2'd1:    begin a_sel = acc_q[1]; b_sel = acc_q[2]; c_sel = acc_q[0]; end
			default: begin a_sel = acc_q[2]; b_sel = acc_q[0]; c_sel = acc_q[1]; end
		endcase
	end

	// Shared squarer
	logic signed [ACC_W-1:0]   mul_op;
	logic signed [2*ACC_W-1:0] prod;
	assign mul_op = cmd.sq_b ? b_sel : c_sel;
	assign prod   = mul_op * mul_op;

	// Square-root step: bring down two radicand bits and try the next root bit
	logic [REM_W-1:0] rem_sh, trial;
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});

	// CORDIC vectoring step
	logic signed [CRD_W-1:0] xs, ys;
	logic signed [Z_W-1:0]   tab;
	assign xs  = x_q >>> cmd.step;
	assign ys  = y_q >>> cmd.step;
	assign tab = atu_pkg::atan_tab(cmd.step);

	// Rounding of Q.16 angle to Q2.13, clamp and z offset
	logic [Z_W-1:0]          z_abs;
	logic [Q_W-1:0]          q_mag, q_clamp;
	logic signed [Q_W:0]     q_sgn, q_off;
	logic                    zero_case;
	always_comb begin
		z_abs     = z_q[Z_W-1] ? Z_W'(-z_q) : z_q;
		q_mag     = Q_W'((z_abs + Z_W'(4)) >> 3);
		q_clamp   = (q_mag > Q_W'(atu_pkg::HALF_PI_Q13)) ? Q_W'(atu_pkg::HALF_PI_Q13) : q_mag;
		zero_case = (sum_q == '0) && (a_sel == '0);
		if (zero_case) begin
			q_sgn = (Q_W+1)'(atu_pkg::HALF_PI_Q13);
		end else if (z_q[Z_W-1]) begin
			q_sgn = -$signed({1'b0, q_clamp});
		end else begin
			q_sgn = $signed({1'b0, q_clamp});
		end
		if (cmd.axis != 2'd2) begin
			q_off = q_sgn;
		end else if (acc_q[2][ACC_W-1]) begin
			q_off = q_sgn + (Q_W+1)'(atu_pkg::HALF_PI_Q13);
		end else begin
			q_off = q_sgn - (Q_W+1)'(atu_pkg::HALF_PI_Q13);
		end
	end

	// Held results and update flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= '0;
				ang_q[k] <= '0;
			end
		end else begin
			if (cmd.hold) begin
				upd_q <= 1'b0;
			end
			if (cmd.load) begin
				upd_q    <= 1'b1;
				acc_q[0] <= scale(raw_x, shamt);
				acc_q[1] <= scale(raw_y, shamt);
				acc_q[2] <= scale(raw_z, shamt);
			end
			if (cmd.store) begin
				ang_q[cmd.axis] <= ANG_W'(q_off);
			end
		end
	end

	// Working registers of the square root and CORDIC
	always_ff @(posedge clk) begin
		if (cmd.sq_b) begin
			sum_q <= SUM_W'(prod);
		end
		if (cmd.sq_c) begin
			sum_q <= sum_q + SUM_W'(prod);
		end
		if (cmd.root_init) begin
			rad_q  <= {sum_q, 16'b0};
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.crd_init) begin
			x_q <= CRD_W'(root_q);
			y_q <= CRD_W'(a_sel) <<< 8;
			z_q <= '0;
		end
		if (cmd.crd_step) begin
			if (!y_q[CRD_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end

	assign updated = upd_q;
	assign accel_x = acc_q[0];
	assign accel_y = acc_q[1];
	assign accel_z = acc_q[2];
	assign angle_x = ang_q[0];
	assign angle_y = ang_q[1];
	assign angle_z = ang_q[2];

endmodule

>>> hw/rtl/accel_tilt_angle_unit_core.sv
// Channel   Direction  Payload
// sample    sink       data_ready, raw_x, raw_y, raw_z
// result    source     updated, accel_x..z, angle_x..z
// cfg       write      cfg_we, cfg_wdata (sensitivity)
//
// A sample with data_ready set presents its result once all three axes are worked through:
// per axis two squarings, root set-up, 26 square-root steps, CORDIC set-up,
// 17 CORDIC steps and a store, on one shared datapath.
// A sample without data_ready gives its result in the next cycle.
// One sample is in flight at a time; a stalled result blocks new samples.
// arst_n clears the held values to zero and sensitivity to the 2 g range.
module accel_tilt_angle_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	atu_sample_if.sink  sample,
	atu_result_if.source result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	atu_pkg::atu_cmd_t cmd;

	atu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample.valid),
		.data_ready (sample.data_ready),
		.out_ready  (result.ready),
		.in_ready   (sample.ready),
		.out_valid  (result.valid),
		.cmd        (cmd)
	);

	atu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.raw_x     (sample.raw_x),
		.raw_y     (sample.raw_y),
		.raw_z     (sample.raw_z),
		.updated   (result.updated),
		.accel_x   (result.accel_x),
		.accel_y   (result.accel_y),
		.accel_z   (result.accel_z),
		.angle_x   (result.angle_x),
		.angle_y   (result.angle_y),
		.angle_z   (result.angle_z)
	);

`ifndef ASSERT_OFF
	// No new sample is taken while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> !result.valid)
		else $error("sample accepted while result pending");

	// A sample without new data is answered at once with a held result.
	a_hold_fast: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready && !sample.data_ready |=>
		result.valid && !result.updated)
		else $error("held result not presented");

	// Tilt angles of x and y stay within plus or minus pi/2.
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($signed(result.angle_x) <= 16'sd12868) &&
		($signed(result.angle_x) >= -16'sd12868))
		else $error("angle_x out of range");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($signed(result.angle_y) <= 16'sd12868) &&
		($signed(result.angle_y) >= -16'sd12868))
		else $error("angle_y out of range");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int          HALF_PERIOD = 6;
	localparam int          CYCLE_LIMIT = 2000000;
	localparam int          DRAIN_WAIT = 200;
	localparam int          ITEMS_PER_PHASE = 226;
	localparam int          HOLD_CYCLES = 3000;
	localparam logic [1:0]  SENS_UNUSED = 2'd3;

	// One input transaction and one result transaction
	typedef struct {
		logic                             data_ready;
		logic signed [atu_pkg::RAW_W-1:0] raw_x;
		logic signed [atu_pkg::RAW_W-1:0] raw_y;
		logic signed [atu_pkg::RAW_W-1:0] raw_z;
	} sample_t;

	typedef struct {
		logic                             updated;
		logic signed [atu_pkg::ACC_W-1:0] accel_x;
		logic signed [atu_pkg::ACC_W-1:0] accel_y;
		logic signed [atu_pkg::ACC_W-1:0] accel_z;
		logic signed [atu_pkg::ANG_W-1:0] angle_x;
		logic signed [atu_pkg::ANG_W-1:0] angle_y;
		logic signed [atu_pkg::ANG_W-1:0] angle_z;
	} tilt_result_t;

	// Tilt predictor with its own copy of the range setting and held values
	class tilt_scoreboard;
		logic [1:0]   sens;
		tilt_result_t held;
		tilt_result_t pending[$];
		int           errors;

		function new();
			sens = atu_pkg::SENS_2G;
			held = '{default: '0};
			errors = 0;
		endfunction

		// Angle of a against the magnitude of (b, c), Q2.13, clamped to +-pi/2.
		function automatic int tilt_angle(longint a, longint b, longint c);
			longint unsigned rad, root, bitv;
			longint x, y, z, xs, ys, q;
			if (b * b + c * c == 0 && a == 0)
				return atu_pkg::HALF_PI_Q13;
			rad = longint'(b * b + c * c) << 16;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > rad)
				bitv >>= 2;
			while (bitv != 0) begin
				if (rad >= root + bitv) begin
					rad -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			x = longint'(root);
			y = a * 256;
			z = 0;
			for (int i = 0; i < atu_pkg::CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys;
					y -= xs;
					z += atu_pkg::atan_tab(i[atu_pkg::STEP_W-1:0]);
				end else begin
					x -= ys;
					y += xs;
					z -= atu_pkg::atan_tab(i[atu_pkg::STEP_W-1:0]);
				end
			end
			if (z >= 0)
				q = (z + 4) >>> 3;
			else
				q = -((-z + 4) >>> 3);
			if (q > atu_pkg::HALF_PI_Q13)
				q = atu_pkg::HALF_PI_Q13;
			if (q < -atu_pkg::HALF_PI_Q13)
				q = -atu_pkg::HALF_PI_Q13;
			return int'(q);
		endfunction

		// Record an accepted sample and queue the result it must produce.
		function void note_sample(sample_t s);
			int     shift;
			longint ax, ay, az;
			int     az_ang;
			tilt_result_t r;
			if (s.data_ready) begin
				shift = (sens == atu_pkg::SENS_8G) ? 2 : (sens == atu_pkg::SENS_4G) ? 1 : 0;
				ax = longint'(s.raw_x) <<< shift;
				ay = longint'(s.raw_y) <<< shift;
				az = longint'(s.raw_z) <<< shift;
				held.accel_x = ax[atu_pkg::ACC_W-1:0];
				held.accel_y = ay[atu_pkg::ACC_W-1:0];
				held.accel_z = az[atu_pkg::ACC_W-1:0];
				held.angle_x = atu_pkg::ANG_W'(tilt_angle(ax, ay, az));
				held.angle_y = atu_pkg::ANG_W'(tilt_angle(ay, az, ax));
				az_ang = tilt_angle(az, ax, ay);
				az_ang = (az < 0) ? az_ang + atu_pkg::HALF_PI_Q13
					: az_ang - atu_pkg::HALF_PI_Q13;
				held.angle_z = atu_pkg::ANG_W'(az_ang);
			end
			r = held;
			r.updated = s.data_ready;
			pending.push_back(r);
		endfunction

		function void cmp(string field, longint e, longint a);
			if (e != a) begin
				errors++;
				$error("%s mismatch: expected %0d, got %0d", field, e, a);
			end
		endfunction

		// Compare a result transaction with the oldest expected one.
		function void check_result(tilt_result_t a);
			tilt_result_t e;
			if (pending.size() == 0) begin
				errors++;
				$error("result transaction with no sample outstanding");
				return;
			end
			e = pending.pop_front();
			cmp("updated", e.updated, a.updated);
			cmp("accel_x", e.accel_x, a.accel_x);
			cmp("accel_y", e.accel_y, a.accel_y);
			cmp("accel_z", e.accel_z, a.accel_z);
			cmp("angle_x", e.angle_x, a.angle_x);
			cmp("angle_y", e.angle_y, a.angle_y);
			cmp("angle_z", e.angle_z, a.angle_z);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	atu_sample_if sample_ch();
	atu_result_if result_ch();

	accel_tilt_angle_unit_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tilt_scoreboard sb;
	int   idle_pct;
	int   stall_pct;
	int   hold_left = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   cycles = 0;

	always #HALF_PERIOD clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off when it is requested.
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Every accepted result transaction is checked.
	always @(posedge clk) begin
		tilt_result_t r;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			r.updated = result_ch.updated;
			r.accel_x = result_ch.accel_x;
			r.accel_y = result_ch.accel_y;
			r.accel_z = result_ch.accel_z;
			r.angle_x = result_ch.angle_x;
			r.angle_y = result_ch.angle_y;
			r.angle_z = result_ch.angle_z;
			sb.check_result(r);
		end
	end

	// Offer one sample, with random idle cycles first, until it is accepted.
	task automatic send_sample(input sample_t s);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data_ready <= s.data_ready;
		sample_ch.raw_x <= s.raw_x;
		sample_ch.raw_y <= s.raw_y;
		sample_ch.raw_z <= s.raw_z;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		sb.note_sample(s);
	endtask

	task automatic send_xyz(input logic rdy, input int x, input int y, input int z);
		sample_t s;
		s.data_ready = rdy;
		s.raw_x = atu_pkg::RAW_W'(x);
		s.raw_y = atu_pkg::RAW_W'(y);
		s.raw_z = atu_pkg::RAW_W'(z);
		send_sample(s);
	endtask

	// Wait until the block is idle, then change the range setting.
	task automatic write_sensitivity(input logic [1:0] v);
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sb.sens = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_axis();
		int sel;
		int corners[5] = '{-32768, 32767, 0, -1, 1};
		sel = $urandom_range(9);
		if (sel < 6)
			return $signed(atu_pkg::RAW_W'($urandom));
		if (sel < 8)
			return $urandom_range(600) - 300;
		if (sel == 8)
			return 0;
		return corners[$urandom_range(4)];
	endfunction

	task automatic random_samples(input int n);
		for (int i = 0; i < n; i++)
			send_xyz($urandom_range(99) < 85, pick_axis(), pick_axis(), pick_axis());
	endtask

	initial begin
		logic [1:0] sens_seq[5] = '{atu_pkg::SENS_8G, atu_pkg::SENS_4G, SENS_UNUSED,
			atu_pkg::SENS_2G, atu_pkg::SENS_8G};
		int idle_seq[5] = '{0, 73, 0, 22, 0};
		int stall_seq[5] = '{0, 0, 73, 22, 0};

		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = atu_pkg::SENS_2G;
		sample_ch.valid = 1'b0;
		sample_ch.data_ready = 1'b0;
		sample_ch.raw_x = '0;
		sample_ch.raw_y = '0;
		sample_ch.raw_z = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: held zeros after reset, extremes and the division corners.
		send_xyz(1'b0, 1234, -5, 77);
		send_xyz(1'b1, 0, 0, 0);
		send_xyz(1'b1, -32768, 0, 0);
		send_xyz(1'b1, 0, 32767, 0);
		send_xyz(1'b1, 0, 0, -32768);
		send_xyz(1'b1, 0, 0, 32767);
		send_xyz(1'b1, 32767, 32767, 32767);
		send_xyz(1'b1, -32768, -32768, -32768);
		send_xyz(1'b1, 1, -1, 1);
		send_xyz(1'b0, -32768, 32767, 0);
		send_xyz(1'b1, 16384, 0, 16384);
		send_xyz(1'b1, -21, 4000, -9);
		write_sensitivity(atu_pkg::SENS_8G);
		send_xyz(1'b1, -32768, -32768, 32767);
		send_xyz(1'b1, 0, 0, -1);
		send_xyz(1'b0, 0, 0, 0);
		write_sensitivity(SENS_UNUSED);
		send_xyz(1'b1, -32768, 100, -200);
		write_sensitivity(atu_pkg::SENS_4G);
		send_xyz(1'b1, 32767, -32768, 0);

		// Random phases, each under its own range setting and idling pattern.
		for (int p = 0; p < 5; p++) begin
			write_sensitivity(sens_seq[p]);
			idle_pct = idle_seq[p];
			stall_pct = stall_seq[p];
			if (p == 4)
				hold_req = 1'b1;
			random_samples(ITEMS_PER_PHASE);
		end

		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
